// ----- rtl/text_statistics_counter_assert.svh -----
// assertion macros used by the checker file
`ifndef TEXT_STATISTICS_COUNTER_ASSERT_SVH
`define TEXT_STATISTICS_COUNTER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, quiet during reset
`define TSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, quiet during reset
`define TSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tsc_pkg.sv -----
`default_nettype none

package tsc_pkg;

  // fixed result widths
  localparam int COUNT_WIDTH = 32;
  localparam int SUM_WIDTH   = 48;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [SUM_WIDTH-1:0]   SUM_MAX   = {SUM_WIDTH{1'b1}};

  // character codes
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_BANG    = 8'h21;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_QUERY   = 8'h3F;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  // input transaction
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_stream;
  } tsc_in_t;

  // result transaction
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] char_total;
    logic [SUM_WIDTH-1:0]   number_sum;
    logic [COUNT_WIDTH-1:0] number_total;
    logic [COUNT_WIDTH-1:0] word_total;
    logic [COUNT_WIDTH-1:0] sentence_total;
    logic [COUNT_WIDTH-1:0] row_total;
  } tsc_out_t;

  // saturating increment
  function automatic logic [COUNT_WIDTH-1:0] bump_count(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH-1:0] r;
    r = (v == COUNT_MAX) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tsc_stats.sv -----
`default_nettype none

module tsc_stats import tsc_pkg::*; #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire tsc_in_t  item_i,
  output tsc_out_t      totals_o
);

  localparam int ExtWidth = ((NUMBER_WIDTH > SUM_WIDTH) ? NUMBER_WIDTH : SUM_WIDTH) + 1;

  // per-stream flags
  logic prev_alnum_q, prev_alnum_d;
  logic in_number_q, in_number_d;
  logic in_word_q, in_word_d;
  logic row_nonempty_q, row_nonempty_d;
  logic sentence_has_word_q, sentence_has_word_d;
  logic [NUMBER_WIDTH-1:0] number_value_q, number_value_d;

  // totals
  logic [SUM_WIDTH-1:0]   sum_q, sum_d;
  logic [COUNT_WIDTH-1:0] char_q, char_d;
  logic [COUNT_WIDTH-1:0] number_q, number_d;
  logic [COUNT_WIDTH-1:0] word_q, word_d;
  logic [COUNT_WIDTH-1:0] sentence_q, sentence_d;
  logic [COUNT_WIDTH-1:0] row_q, row_d;

  logic                    eos;
  logic [7:0]              b;
  logic                    is_digit, is_letter, is_punct, is_newline;
  logic [3:0]              digit_diff;
  logic                    num_start, num_run, num_end;
  logic                    word_start, word_end;
  logic                    row_mid, sent_mid, row_end, sent_end;
  logic [NUMBER_WIDTH-1:0] base_value;
  logic [ExtWidth-1:0]     sum_ext;

  // byte classification; end of stream acts as a zero byte
  always_comb begin
    eos        = item_i.end_of_stream;
    b          = eos ? CHAR_NUL : item_i.char_byte;
    is_digit   = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    is_letter  = ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z)) ||
                 ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z));
    is_punct   = !eos && ((b == CHAR_DOT) || (b == CHAR_BANG) || (b == CHAR_QUERY));
    is_newline = eos || (b == CHAR_NEWLINE);
    digit_diff = 4'(b - CHAR_ZERO);
  end

  // number, word, sentence and row update
  always_comb begin
    num_start  = !prev_alnum_q && is_digit;
    num_run    = is_digit && (in_number_q || num_start);
    num_end    = !is_digit && in_number_q;
    word_start = !prev_alnum_q && is_letter;
    word_end   = !is_letter && in_word_q;

    // value accumulates in decimal and wraps
    base_value     = num_start ? '0 : number_value_q;
    number_value_d = num_run ?
                     ((base_value << 3) + (base_value << 1) + NUMBER_WIDTH'(digit_diff)) :
                     '0;
    in_number_d    = num_run;
    in_word_d      = is_letter && (in_word_q || word_start);

    // saturating sum of completed numbers
    sum_ext = ExtWidth'(sum_q) + ExtWidth'(number_value_q);
    sum_d   = sum_q;
    if (num_end) begin
      sum_d = (sum_ext > ExtWidth'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_WIDTH-1:0];
    end

    number_d = num_end ? bump_count(number_q) : number_q;
    word_d   = word_end ? bump_count(word_q) : word_q;

    row_mid  = row_nonempty_q || num_end || word_end;
    sent_mid = sentence_has_word_q || word_end;

    sent_end   = is_punct && sent_mid;
    sentence_d = sent_end ? bump_count(sentence_q) : sentence_q;
    sentence_has_word_d = sent_mid && !sent_end && !eos;

    row_end        = is_newline && row_mid;
    row_d          = row_end ? bump_count(row_q) : row_q;
    row_nonempty_d = row_mid && !row_end && !eos;

    prev_alnum_d = !eos && (is_digit || is_letter);
    char_d       = eos ? char_q : bump_count(char_q);
  end

  // state advances once per processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_alnum_q        <= 1'b0;
      in_number_q         <= 1'b0;
      in_word_q           <= 1'b0;
      row_nonempty_q      <= 1'b0;
      sentence_has_word_q <= 1'b0;
      number_value_q      <= '0;
      sum_q               <= '0;
      char_q              <= '0;
      number_q            <= '0;
      word_q              <= '0;
      sentence_q          <= '0;
      row_q               <= '0;
    end else if (step_i) begin
      prev_alnum_q        <= prev_alnum_d;
      in_number_q         <= in_number_d;
      in_word_q           <= in_word_d;
      row_nonempty_q      <= row_nonempty_d;
      sentence_has_word_q <= sentence_has_word_d;
      number_value_q      <= number_value_d;
      sum_q               <= sum_d;
      char_q              <= char_d;
      number_q            <= number_d;
      word_q              <= word_d;
      sentence_q          <= sentence_d;
      row_q               <= row_d;
    end
  end

  // totals registers double as the result register
  always_comb begin
    totals_o.char_total     = char_q;
    totals_o.number_sum     = sum_q;
    totals_o.number_total   = number_q;
    totals_o.word_total     = word_q;
    totals_o.sentence_total = sentence_q;
    totals_o.row_total      = row_q;
  end

endmodule

`default_nettype wire

// ----- rtl/text_statistics_counter.sv -----
// Text statistics counter.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one text byte
// or an end-of-stream marker per transaction. Output channel (out_valid_o /
// out_stall_i / out_data_o) returns one result per input transaction: the
// running byte, number, word, sentence and row totals plus the number sum.
// Each input transaction lands in an input register; the update logic then
// runs and the totals registers, which form the output register, load the
// new result. One transaction per cycle is sustained while the receiver
// does not stall, with a single update stage between the two registers.
// When the receiver stalls, the result holds; if the input register is
// empty, one more input transaction is still taken into it, after which
// in_stall_o follows out_stall_i until the result is taken.
// Reset clears all totals, the per-stream flags and both valid bits.
// An end-of-stream transaction closes any open number, word and row and
// clears the per-stream flags; totals carry over into the next stream.
`default_nettype none

module text_statistics_counter import tsc_pkg::*; #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire tsc_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output tsc_out_t      out_data_o
);

  logic    in_valid_q, in_valid_d;
  tsc_in_t in_q;
  logic    out_valid_q, out_valid_d;
  logic    advance, in_accept, step;

  // handshake control
  always_comb begin
    advance     = !out_valid_q || !out_stall_i;
    in_stall_o  = in_valid_q && !advance;
    in_accept   = in_valid_i && !in_stall_o;
    step        = in_valid_q && advance;
    in_valid_d  = in_accept || (in_valid_q && !advance);
    out_valid_d = step || (out_valid_q && !advance);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  // update logic and totals
  tsc_stats #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_q),
    .totals_o(out_data_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/tsc_checker.sv -----
`default_nettype none

`include "text_statistics_counter_assert.svh"

module tsc_checker import tsc_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire tsc_out_t out_data_o
);

  logic     in_acc;
  logic     out_acc;
  logic     out_hold;
  logic     totals_grew;
  tsc_out_t last_q;

  // transaction strobes
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign out_hold = out_valid_o && out_stall_i;

  // totals seen in the previous cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else begin
      last_q <= out_data_o;
    end
  end

  // every total at least as large as in the previous cycle
  assign totals_grew = (out_data_o.char_total >= last_q.char_total) &&
                       (out_data_o.number_sum >= last_q.number_sum) &&
                       (out_data_o.number_total >= last_q.number_total) &&
                       (out_data_o.word_total >= last_q.word_total) &&
                       (out_data_o.sentence_total >= last_q.sentence_total) &&
                       (out_data_o.row_total >= last_q.row_total);

  // stalled result stays put
  `TSC_ASSERT_NEXT(a_out_hold, out_hold, out_valid_o && $stable(out_data_o), "result changed")

  // input backpressure only comes from a stalled result
  `TSC_ASSERT_SAME(a_stall_cause, in_stall_o, out_hold, "input stalled without output stall")

  // a new result follows an accepted input transaction through the input register
  `TSC_ASSERT_SAME(a_latency, $rose(out_valid_o), $past(in_acc, 2), "result without input")

  // totals never decrease from one result to the next
  `TSC_ASSERT_NEXT(a_monotonic, out_acc, !out_valid_o || totals_grew, "totals decreased")

endmodule

bind text_statistics_counter tsc_checker u_tsc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
